### hdl/int_to_float_scale_multiply_macros.svh
// Assertion macros for the scale multiply block
`ifndef INT_TO_FLOAT_SCALE_MULTIPLY_MACROS_SVH
`define INT_TO_FLOAT_SCALE_MULTIPLY_MACROS_SVH

// implication checked every clock, disabled in reset
`define ITF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ITF_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### hdl/itf_pkg.sv
// ----------------------------------------------------------------------------
// itf_pkg
// Shared types and constants for the int to float scale multiply block.
// ----------------------------------------------------------------------------
package itf_pkg;
    localparam logic [31:0] QNAN_BITS  = 32'h7FC0_0000;
    localparam logic [31:0] SCALE_ONE  = 32'h3F80_0000;

    // operand stage -> multiply stage
    typedef struct packed {
        logic        sign;
        logic        special;    // result fully known
        logic [31:0] special_bits;
        logic [23:0] ma;         // converted score significand
        logic [23:0] mb;         // scale significand, normalized
        logic signed [10:0] ex;  // exponent of product lsb
    } t_ops;
endpackage

### hdl/int_to_float_scale_multiply.sv
// ----------------------------------------------------------------------------
// int_to_float_scale_multiply
// Signed 32-bit score -> fp32 (nearest even), times fp32 scale register.
// ----------------------------------------------------------------------------
// Usage:
//  - Pulse start with i_score; busy is always low, so one score is
//    taken every cycle.
//  - o_done is then high for one cycle with o_scaled_bits, after
//    one input register stage (convert/unpack) and one result register
//    (multiply/round). Throughput is one item per clock.
//  - The scale is written through i_cfg_valid/o_cfg_ready/i_cfg_data,
//    always ready; write it only while no score is in flight.
//  - Synchronous reset drops items in flight and sets the scale to 1.0.
//  - The receiver cannot stall; results must be taken when o_done is high.
//  - NaN results come out as 0x7FC00000.
// ----------------------------------------------------------------------------
`include "int_to_float_scale_multiply_macros.svh"
module int_to_float_scale_multiply import itf_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_score,
    output logic        o_done,
    output logic [31:0] o_scaled_bits,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data
);
    logic [31:0] r_scale;
    logic        r_v1, r_v2;
    t_ops        n_ops, r_ops;
    logic [31:0] n_bits, r_bits;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= SCALE_ONE;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) r_scale <= i_cfg_data;
            r_v1 <= start;
            r_v2 <= r_v1;
        end
        r_ops   <= n_ops;
        r_bits  <= n_bits;
    end

    itf_unpack u_unpack (.i_score(i_score), .i_scale(r_scale), .o_ops(n_ops));
    itf_mul_round u_mul (.i_ops(r_ops), .o_bits(n_bits));

    assign o_done        = r_v2;
    assign o_scaled_bits = r_bits;

    `ITF_ASSERT_NXT(a_pipe, i_clk, i_rst_n, start, r_v1)
    `ITF_ASSERT_NXT(a_done, i_clk, i_rst_n, r_v1, o_done)
    `ITF_ASSERT_IMP(a_nan, i_clk, i_rst_n,
        o_done && o_scaled_bits[30:23] == 8'hFF && o_scaled_bits[22:0] != 23'd0,
        o_scaled_bits == QNAN_BITS)
endmodule

### hdl/itf_unpack.sv
// ----------------------------------------------------------------------------
// itf_unpack
// Converts the score to a rounded 24-bit significand and normalizes the
// scale; resolves NaN, infinity and zero cases.
// ----------------------------------------------------------------------------
module itf_unpack import itf_pkg::*; (
    input  logic [31:0] i_score,
    input  logic [31:0] i_scale,
    output t_ops        o_ops
);
    logic        sa, sb;
    logic [31:0] mag;
    logic [7:0]  eb;
    logic [22:0] fb;
    logic [4:0]  ta, tb;
    logic [31:0] norm_a;
    logic [7:0]  sh;
    logic        g, st, inc;
    logic [24:0] qa;
    logic [23:0] ma;
    logic signed [10:0] xa, xb;
    logic [23:0] fbn;

    always_comb begin
        sa  = i_score[31];
        mag = sa ? (32'd0 - i_score) : i_score;
        sb  = i_scale[31];
        eb  = i_scale[30:23];
        fb  = i_scale[22:0];
        // leading one of magnitude
        ta = 5'd0;
        for (int i = 0; i < 32; i++) if (mag[i]) ta = 5'(i);
        norm_a = mag << (5'd31 - ta);
        g   = norm_a[7];
        st  = |norm_a[6:0];
        inc = g & (st | norm_a[8]);
        qa  = {1'b0, norm_a[31:8]} + {24'd0, inc};
        // lsb exponent of converted value: ta-23, plus carry
        if (qa[24]) begin
            ma = qa[24:1];
            xa = 11'(signed'({6'd0, ta})) - 11'sd22;
        end else begin
            ma = qa[23:0];
            xa = 11'(signed'({6'd0, ta})) - 11'sd23;
        end
        // scale
        tb = 5'd0;
        for (int i = 0; i < 23; i++) if (fb[i]) tb = 5'(i);
        if (eb == 8'd0) begin
            fbn = {1'b0, fb} << (5'd23 - tb);
            xb  = -11'sd149 - 11'(signed'({6'd0, 5'd23 - tb}));
        end else begin
            fbn = {1'b1, fb};
            xb  = 11'(signed'({3'd0, eb})) - 11'sd150;
        end
        sh = 8'd0;
        o_ops.sign = sa ^ sb;
        o_ops.ma   = ma;
        o_ops.mb   = fbn;
        o_ops.ex   = xa + xb;
        o_ops.special = 1'b1;
        o_ops.special_bits = {sa ^ sb, 31'd0};
        if (eb == 8'hFF && fb != 23'd0) begin
            o_ops.special_bits = QNAN_BITS;
        end else if (eb == 8'hFF) begin
            o_ops.special_bits = (mag == 32'd0) ? QNAN_BITS : {sa ^ sb, 31'h7F80_0000};
        end else if (mag == 32'd0 || (eb == 8'd0 && fb == 23'd0)) begin
            o_ops.special_bits = {sa ^ sb, 31'd0};
        end else begin
            o_ops.special = 1'b0;
        end
        o_ops.special = o_ops.special | (|sh);
    end
endmodule

### hdl/itf_mul_round.sv
// ----------------------------------------------------------------------------
// itf_mul_round
// 24x24 significand product, normalize and round to nearest even with
// subnormal and overflow handling.
// ----------------------------------------------------------------------------
module itf_mul_round import itf_pkg::*; (
    input  t_ops        i_ops,
    output logic [31:0] o_bits
);
    logic [47:0] p;
    logic        top;
    logic signed [11:0] lsb;   // exponent of kept lsb, before clamp
    logic [5:0]  sh;           // right shift of p
    logic [47:0] q0, rem_mask;
    logic        g, st;
    logic [24:0] q;
    logic signed [11:0] biased;
    logic [47:0] shifted;

    always_comb begin
        p   = i_ops.ma * i_ops.mb;
        top = p[47];
        // normalized shift keeps 24 bits
        lsb = 12'(i_ops.ex) + (top ? 12'sd24 : 12'sd23);
        if (lsb < -12'sd149) begin
            if ((-12'sd149 - lsb) > 12'sd30) sh = 6'd50;
            else sh = 6'((top ? 12'sd24 : 12'sd23) + (-12'sd149 - lsb));
            lsb = -12'sd149;
        end else begin
            sh = top ? 6'd24 : 6'd23;
        end
        rem_mask = 48'd0;
        shifted  = 48'd0;
        if (sh >= 6'd49) begin
            q0 = 48'd0; g = 1'b0; st = 1'b1;
        end else begin
            q0       = p >> sh;
            rem_mask = (48'd1 << sh) - 48'd1;
            shifted  = p & rem_mask;
            g  = p[sh - 6'd1];
            st = |(shifted & ~(48'd1 << (sh - 6'd1)));
        end
        q = q0[24:0] + {24'd0, g & (st | q0[0])};
        if (q[24]) begin
            q   = q >> 1;
            lsb = lsb + 12'sd1;
        end
        biased = lsb + 12'sd150;
        if (q[23]) begin
            if (biased >= 12'sd255) o_bits = {i_ops.sign, 31'h7F80_0000};
            else o_bits = {i_ops.sign, biased[7:0], q[22:0]};
        end else begin
            o_bits = {i_ops.sign, 8'd0, q[22:0]};
        end
        if (i_ops.special) o_bits = i_ops.special_bits;
    end
endmodule

### dv/tb_int_to_float_scale_multiply.sv
// ----------------------------------------------------------------------------
// tb_int_to_float_scale_multiply
// Drives signed scores through the convert-and-scale block under a series of
// scale settings (specials, extremes, random patterns) and checks every
// product bit pattern against an integer-only fp32 predictor.
// ----------------------------------------------------------------------------
module tb_int_to_float_scale_multiply;
    import itf_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 6;

    class scaled_product_board;
        logic [31:0] scale;
        logic [31:0] pending[$];
        int          n_checked;
        int          n_errors;

        function new();
            scale = SCALE_ONE;
            n_checked = 0;
            n_errors = 0;
        endfunction

        // round sign * sig * 2^ex to fp32, nearest even
        function logic [31:0] round_to_fp32(logic s, logic [63:0] sig, int ex);
            int          t;
            int          lsb;
            int          sh;
            logic [63:0] q;
            logic [63:0] rem;
            logic [63:0] half;
            t = 0;
            while (t < 63 && (sig >> (t + 1)) != 0) t++;
            lsb = ex + t - 23;
            if (lsb < -149) lsb = -149;
            sh = lsb - ex;
            if (sh <= 0) begin
                q = sig << (-sh);
            end else if (sh > 62) begin
                q = 0;
            end else begin
                rem  = sig & ((64'd1 << sh) - 1);
                half = 64'd1 << (sh - 1);
                q    = sig >> sh;
                if (rem > half || (rem == half && q[0])) q++;
            end
            if (q == (64'd1 << 24)) begin
                q = q >> 1;
                lsb++;
            end
            if (q >= (64'd1 << 23)) begin
                if (lsb + 150 >= 255) return {s, 8'hFF, 23'd0};
                return {s, 8'(lsb + 150), q[22:0]};
            end
            return {s, q[30:0]};
        endfunction

        // finite nonzero pattern -> 24-bit significand, exponent of its lsb
        function void split_fp32(logic [31:0] bits, output logic [63:0] m, output int ex);
            logic [23:0] f;
            f = {1'b0, bits[22:0]};
            if (bits[30:23] == 0) begin
                ex = -149;
                while (!f[23]) begin
                    f = f << 1;
                    ex--;
                end
                m = {40'd0, f};
            end else begin
                m = {40'd0, 1'b1, bits[22:0]};
                ex = int'(bits[30:23]) - 150;
            end
        endfunction

        function logic [31:0] scaled_score(logic [31:0] raw);
            logic        sa;
            logic        sb;
            logic [31:0] mag;
            logic [31:0] conv;
            logic [63:0] ma;
            logic [63:0] mb;
            int          xa;
            int          xb;
            sa  = raw[31];
            sb  = scale[31];
            mag = sa ? -raw : raw;
            if (scale[30:23] == 8'hFF && scale[22:0] != 0) return QNAN_BITS;
            if (scale[30:23] == 8'hFF)
                return (mag == 0) ? QNAN_BITS : {sa ^ sb, 8'hFF, 23'd0};
            if (mag == 0 || scale[30:0] == 0) return {sa ^ sb, 31'd0};
            conv = round_to_fp32(sa, {32'd0, mag}, 0);
            split_fp32(conv, ma, xa);
            split_fp32(scale, mb, xb);
            return round_to_fp32(sa ^ sb, ma * mb, xa + xb);
        endfunction

        function void note_score(logic [31:0] raw);
            pending.push_back(scaled_score(raw));
        endfunction

        function void check_result(logic [31:0] got);
            logic [31:0] want;
            if (pending.size() == 0) begin
                $error("unexpected result scaled_bits=%h", got);
                n_errors++;
                return;
            end
            want = pending.pop_front();
            n_checked++;
            if (got !== want) begin
                $error("scaled_bits mismatch: expected %h actual %h (scale %h)",
                       want, got, scale);
                n_errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [31:0] i_score;
    logic        o_done;
    logic [31:0] o_scaled_bits;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [31:0] i_cfg_data;

    scaled_product_board board;
    int cycles;
    int n_sent;
    int n_scales;
    int max_gap;

    int_to_float_scale_multiply dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_score      (i_score),
        .o_done       (o_done),
        .o_scaled_bits(o_scaled_bits),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (i_rst_n && o_done) board.check_result(o_scaled_bits);
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("** int_to_float_scale_multiply: FAILED **");
            $finish;
        end
    end

    task automatic send_score(logic [31:0] v);
        int gap;
        gap = (max_gap == 0) ? 0 : $urandom_range(0, max_gap);
        repeat (gap) begin
            @(negedge i_clk);
            start = 1'b0;
        end
        @(negedge i_clk);
        start   = 1'b1;
        i_score = v;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        board.note_score(v);
        n_sent++;
    endtask

    task automatic write_scale(logic [31:0] v);
        @(negedge i_clk);
        start = 1'b0;
        while (board.pending.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data  = v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        board.scale = v;
        n_scales++;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    function automatic logic [31:0] pick_score();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(0, 5))
            0: return r;
            1: return r >> $urandom_range(0, 31);               // small positive
            2: return -(r >> $urandom_range(0, 31));            // small negative
            3: return {r[31], {7{~r[31]}}, r[23:0]} & ~32'hFF | 32'h80;  // ties near 2^31
            4: return (r | 32'h1) << $urandom_range(24, 31) >> $urandom_range(0, 7);
            default: begin
                case ($urandom_range(0, 4))
                    0: return 32'h8000_0000;
                    1: return 32'h7FFF_FFFF;
                    2: return 32'h0;
                    3: return 32'hFFFF_FFFF;
                    default: return 32'h1;
                endcase
            end
        endcase
    endfunction

    function automatic logic [31:0] pick_scale();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(0, 6))
            0: return r;
            1: return {r[31], 8'($urandom_range(100, 154)), r[22:0]};   // ordinary
            2: return {r[31], 8'($urandom_range(0, 40)), r[22:0]};      // underflow
            3: return {r[31], 8'($urandom_range(200, 254)), r[22:0]};   // overflow
            4: return {r[31], 8'h00, r[22:0]};                          // subnormal
            5: return {r[31], 8'hFF, (r[0] ? r[22:0] : 23'd0)};        // inf / NaN
            default: return {r[31], 31'd0};                             // zero
        endcase
    endfunction

    initial begin
        logic [31:0] edge_scores[12];
        logic [31:0] edge_scales[10];
        board       = new();
        cycles      = 0;
        n_sent      = 0;
        n_scales    = 0;
        max_gap     = 0;
        start       = 1'b0;
        i_score     = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        i_rst_n     = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset scale is 1.0: pure conversion, rounding ties included
        edge_scores = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                        32'd16777217, 32'd16777219, -32'd16777217, 32'h7FFF_FFC0,
                        32'h7FFF_FF40, 32'h8000_0001, 32'h0100_0003};
        foreach (edge_scores[k]) send_score(edge_scores[k]);

        // specials: zero, inf, NaN, overflow, subnormal, underflow
        edge_scales = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
                        32'h7FC0_0001, 32'h7F7F_FFFF, 32'h0000_0001, 32'h8080_0000,
                        32'h2F00_0000, 32'hFFFF_FFFF};
        foreach (edge_scales[k]) begin
            write_scale(edge_scales[k]);
            send_score(32'h0);
            send_score(k[0] ? 32'h8000_0000 : 32'h7FFF_FFFF);
        end

        for (int ph = 0; ph < 40; ph++) begin
            write_scale(ph == 0 ? 32'hFFFF_FFFF : ph == 1 ? 32'h0 : pick_scale());
            max_gap = 15;
            repeat (38) send_score(pick_score());
        end

        @(negedge i_clk);
        start = 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("sent %0d scores under %0d scale settings, %0d products checked",
                 n_sent, n_scales + 1, board.n_checked);
        if (board.n_errors == 0 && board.pending.size() == 0) begin
            $display("** int_to_float_scale_multiply: PASSED **");
        end else begin
            $display("** int_to_float_scale_multiply: FAILED **");
        end
        $finish;
    end
endmodule
